>>> src/brpc_pkg.sv
// Shared types and constants for the button press relay controller.
// No dependencies; imported by every module of the block.
package brpc_pkg;

    localparam int CIRCUITS_DEF = 4;
    localparam int AGE_BITS_DEF = 16;
    localparam int CFG_W        = 16;
    localparam int MASK_W       = 4;

    // request types
    localparam logic [1:0] REQ_TICK   = 2'd0;
    localparam logic [1:0] REQ_SET    = 2'd1;
    localparam logic [1:0] REQ_STATUS = 2'd2;

    // configuration register indexes
    localparam logic [1:0] CFG_LONG  = 2'd0;
    localparam logic [1:0] CFG_SHORT = 2'd1;
    localparam logic [1:0] CFG_BLINK = 2'd2;

    localparam logic [CFG_W-1:0] LONG_RST  = 16'd2000;
    localparam logic [CFG_W-1:0] SHORT_RST = 16'd800;
    localparam logic [CFG_W-1:0] BLINK_RST = 16'd500;

    // per-beat command broadcast to every circuit
    typedef struct packed {
        logic tick;
        logic host_set;
        logic status_rd;
        logic flip;
        logic phase;
    } t_cmd;

    // state of one circuit after the current beat; changed is the flag before it
    typedef struct packed {
        logic en;
        logic on;
        logic led;
        logic changed;
    } t_stat;

endpackage

>>> src/brpc_blink.sv
// Blink interval counter and phase for the LED of enabled, off circuits.
// Depends on brpc_pkg.
module brpc_blink
    import brpc_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_tick,
    input  logic [CFG_W-1:0] i_interval,
    output logic             o_flip,
    output logic             o_phase
);

    logic [CFG_W-1:0] r_cnt;
    logic [CFG_W-1:0] n_cnt;
    logic             r_phase;

    always_comb begin
        o_flip  = i_tick && (r_cnt >= i_interval);
        o_phase = r_phase ^ o_flip;
        n_cnt   = r_cnt;
        if (i_tick) begin
            n_cnt = o_flip ? '0 : r_cnt + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt   <= '0;
            r_phase <= 1'b0;
        end else begin
            r_cnt   <= n_cnt;
            r_phase <= o_phase;
        end
    end

endmodule

>>> src/brpc_circuit.sv
// State and press classification of one circuit: press timer, short and
// long press checks, host set, LED. Depends on brpc_pkg.
module brpc_circuit
    import brpc_pkg::*;
#(
    parameter int AGE_BITS = AGE_BITS_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_cmd             i_cmd,
    input  logic             i_level,
    input  logic             i_sel,
    input  logic             i_set_enable,
    input  logic             i_set_on,
    input  logic [CFG_W-1:0] i_long_ms,
    input  logic [CFG_W-1:0] i_short_ms,
    output t_stat            o_stat
);

    localparam int CW = (AGE_BITS > CFG_W) ? AGE_BITS : CFG_W;
    localparam logic [AGE_BITS-1:0] AGE_MAX = '1;

    logic                r_en, r_on, r_led, r_rel, r_hnd, r_chg;
    logic [AGE_BITS-1:0] r_age;
    logic                n_en, n_on, n_led, n_rel, n_hnd, n_chg;
    logic [AGE_BITS-1:0] n_age;
    logic                press_start;

    always_comb begin
        n_en  = r_en;
        n_on  = r_on;
        n_led = r_led;
        n_rel = r_rel;
        n_hnd = r_hnd;
        n_chg = r_chg;
        n_age = r_age;
        press_start = !i_level && r_rel;

        if (i_cmd.tick) begin
            n_age = press_start ? '0 : ((r_age == AGE_MAX) ? r_age : r_age + 1'b1);
            n_rel = i_level;
            if (press_start) begin
                n_hnd = 1'b0;
            end
            if (!n_hnd) begin
                if (CW'(n_age) > CW'(i_long_ms)) begin
                    n_en  = !n_en;
                    n_chg = 1'b1;
                    if (!n_en) begin
                        n_on  = 1'b0;
                        n_led = 1'b0;
                    end
                end
                if (n_rel && (CW'(n_age) < CW'(i_short_ms)) && n_en) begin
                    n_on  = !n_on;
                    n_led = n_on;
                    n_chg = 1'b1;
                end
                if (n_rel) begin
                    n_hnd = 1'b1;
                end
                // a long press leaves the press handled even while held
                if (CW'(n_age) > CW'(i_long_ms)) begin
                    n_hnd = 1'b1;
                end
            end
            if (i_cmd.flip && n_en && !n_on) begin
                n_led = i_cmd.phase;
            end
        end else if (i_cmd.host_set && i_sel) begin
            n_en  = i_set_enable;
            n_chg = 1'b1;
            if (!i_set_enable) begin
                n_on  = 1'b0;
                n_led = 1'b0;
            end else begin
                n_on  = i_set_on;
                n_led = i_set_on;
            end
        end else if (i_cmd.status_rd) begin
            n_chg = 1'b0;
        end

        o_stat.en      = n_en;
        o_stat.on      = n_on;
        o_stat.led     = n_led;
        o_stat.changed = r_chg;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_en  <= 1'b0;
            r_on  <= 1'b0;
            r_led <= 1'b0;
            r_rel <= 1'b1;
            r_hnd <= 1'b1;
            r_chg <= 1'b1;
            r_age <= '0;
        end else begin
            r_en  <= n_en;
            r_on  <= n_on;
            r_led <= n_led;
            r_rel <= n_rel;
            r_hnd <= n_hnd;
            r_chg <= n_chg;
            r_age <= n_age;
        end
    end

endmodule

>>> src/button_press_relay_controller.sv
// Button press relay controller, top level.
// Input channel: i_in_valid / o_in_stall with req_type, buttons_level,
// circuit, set_enable, set_on. A tick beat stands for one millisecond and
// carries the active-low button pins; a set beat writes enable and on of one
// circuit; a status beat reports and clears the changed flags.
// Output channel: o_out_valid / i_out_stall, one result beat per input beat,
// carrying the enabled, relay and LED masks after the beat and, on a status
// beat, whether anything changed since the last status read.
// A beat is held in the input register, then goes through the circuit update
// into the result register. Throughput is one beat per cycle unless the
// receiver stalls; the circuit state update is a single compare-and-select pass.
// While the receiver stalls, the result holds, one further beat waits in the
// input register, and o_in_stall rises only when both are full.
// Configuration: i_cfg_we writes i_cfg_data to register i_cfg_idx (0 long
// press, 1 short press, 2 blink interval); write only while idle.
// Synchronous active-low reset restores the register defaults, clears both
// stages and sets all circuits off and disabled with changed flags set.
// Depends on brpc_pkg, brpc_blink, brpc_circuit.
module button_press_relay_controller
    import brpc_pkg::*;
#(
    parameter int CIRCUITS = CIRCUITS_DEF,
    parameter int AGE_BITS = AGE_BITS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  logic [1:0]        i_req_type,
    input  logic [MASK_W-1:0] i_buttons_level,
    input  logic [1:0]        i_circuit,
    input  logic              i_set_enable,
    input  logic              i_set_on,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output logic [MASK_W-1:0] o_enabled_mask,
    output logic [MASK_W-1:0] o_relay_mask,
    output logic [MASK_W-1:0] o_led_mask,
    output logic              o_status_changed,
    input  logic              i_cfg_we,
    input  logic [1:0]        i_cfg_idx,
    input  logic [CFG_W-1:0]  i_cfg_data
);

    logic [CFG_W-1:0]  r_long_ms, r_short_ms, r_blink_ms;

    logic              r_in_valid;
    logic [1:0]        r_req;
    logic [MASK_W-1:0] r_levels;
    logic [1:0]        r_circuit;
    logic              r_set_enable, r_set_on;

    logic              r_out_valid;
    logic [MASK_W-1:0] r_en_mask, r_on_mask, r_led_mask;
    logic              r_status;

    logic              advance, proc, in_take;
    logic              flip, phase;
    t_cmd              cmd;
    t_stat             stat [CIRCUITS];
    logic [CIRCUITS-1:0] chg_vec;
    logic [MASK_W-1:0] en_mask, on_mask, led_mask;

    assign advance    = !r_out_valid || !i_out_stall;
    assign proc       = r_in_valid && advance;
    assign o_in_stall = r_in_valid && !advance;
    assign in_take    = i_in_valid && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_long_ms  <= LONG_RST;
            r_short_ms <= SHORT_RST;
            r_blink_ms <= BLINK_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_LONG:  r_long_ms  <= i_cfg_data;
                CFG_SHORT: r_short_ms <= i_cfg_data;
                CFG_BLINK: r_blink_ms <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_take) begin
            r_in_valid <= 1'b1;
        end else if (proc) begin
            r_in_valid <= 1'b0;
        end
        if (in_take) begin
            r_req        <= i_req_type;
            r_levels     <= i_buttons_level;
            r_circuit    <= i_circuit;
            r_set_enable <= i_set_enable;
            r_set_on     <= i_set_on;
        end
    end

    brpc_blink u_blink (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_tick     (cmd.tick),
        .i_interval (r_blink_ms),
        .o_flip     (flip),
        .o_phase    (phase)
    );

    always_comb begin
        cmd.tick      = proc && (r_req == REQ_TICK);
        cmd.host_set  = proc && (r_req == REQ_SET);
        cmd.status_rd = proc && (r_req == REQ_STATUS);
        cmd.flip      = flip;
        cmd.phase     = phase;
    end

    for (genvar gi = 0; gi < CIRCUITS; gi++) begin : g_circ
        logic lvl;
        if (gi < MASK_W) begin : g_pin
            assign lvl = r_levels[gi];
        end else begin : g_nopin
            assign lvl = 1'b1;
        end

        brpc_circuit #(
            .AGE_BITS (AGE_BITS)
        ) u_circuit (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_cmd        (cmd),
            .i_level      (lvl),
            .i_sel        (int'(r_circuit) == gi),
            .i_set_enable (r_set_enable),
            .i_set_on     (r_set_on),
            .i_long_ms    (r_long_ms),
            .i_short_ms   (r_short_ms),
            .o_stat       (stat[gi])
        );

        assign chg_vec[gi] = stat[gi].changed;
    end

    for (genvar gm = 0; gm < MASK_W; gm++) begin : g_mask
        if (gm < CIRCUITS) begin : g_used
            assign en_mask[gm]  = stat[gm].en;
            assign on_mask[gm]  = stat[gm].on;
            assign led_mask[gm] = stat[gm].led;
        end else begin : g_unused
            assign en_mask[gm]  = 1'b0;
            assign on_mask[gm]  = 1'b0;
            assign led_mask[gm] = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= r_in_valid;
        end
        if (proc) begin
            r_en_mask  <= en_mask;
            r_on_mask  <= on_mask;
            r_led_mask <= led_mask;
            r_status   <= cmd.status_rd && (|chg_vec);
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_enabled_mask   = r_en_mask;
    assign o_relay_mask     = r_on_mask;
    assign o_led_mask       = r_led_mask;
    assign o_status_changed = r_status;

endmodule

>>> src/brpc_checker.sv
// Port-level checks for the button press relay controller, bound to the top.
// Depends on brpc_pkg and button_press_relay_controller.
module brpc_checker
    import brpc_pkg::*;
(
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              o_out_valid,
    input logic              i_out_stall,
    input logic [MASK_W-1:0] o_enabled_mask,
    input logic [MASK_W-1:0] o_relay_mask,
    input logic [MASK_W-1:0] o_led_mask,
    input logic              o_status_changed
);

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_enabled_mask)
            && $stable(o_relay_mask) && $stable(o_led_mask) && $stable(o_status_changed))
        else $error("result beat changed while stalled");

    a_rst: assert property (@(posedge i_clk) !i_rst_n |=> !o_out_valid)
        else $error("result valid right after reset");

    a_on_en: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_relay_mask & ~o_enabled_mask) == '0)
        else $error("circuit on while disabled");

    a_led: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_led_mask & ~o_enabled_mask) == '0
            && (o_relay_mask & ~o_led_mask) == '0)
        else $error("LED inconsistent with enable or on state");

endmodule

bind button_press_relay_controller brpc_checker u_brpc_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .o_out_valid      (o_out_valid),
    .i_out_stall      (i_out_stall),
    .o_enabled_mask   (o_enabled_mask),
    .o_relay_mask     (o_relay_mask),
    .o_led_mask       (o_led_mask),
    .o_status_changed (o_status_changed)
);
